### sv/utt_pkg.sv
// Package for the UTF-16/UTF-32 to UTF-8 transcoder.
// Holds payload and job types, code point constants and the UTF-8 byte helpers.
// No dependencies.
package utt_pkg;

    // Defaults for the top-level parameters
    localparam int UNIT_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Code point constants
    localparam logic [31:0] HI_FIRST    = 32'h0000_D800;
    localparam logic [31:0] HI_LAST     = 32'h0000_DBFF;
    localparam logic [31:0] LO_FIRST    = 32'h0000_DC00;
    localparam logic [31:0] LO_LAST     = 32'h0000_DFFF;
    localparam logic [31:0] MAX_CP      = 32'h0010_FFFF;
    localparam logic [20:0] REPLACEMENT = 21'h0_FFFD;
    localparam logic [20:0] PAIR_BASE   = 21'h1_0000;

    // Encoded length minus one
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // Lead and continuation markers
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    typedef struct packed {
        logic [31:0] code_unit;
        logic        end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
        logic       text_done;
    } t_out_item;

    // One queued job: optional replacement prefix, then an optional code point
    typedef struct packed {
        logic        has_repl;
        logic        has_cp;
        logic [20:0] cp;
        logic [1:0]  len_m1;
        logic        eot;
    } t_job;

    // Number of UTF-8 bytes for a code point, minus one
    function automatic logic [1:0] utt_len_m1(input logic [20:0] cp);
        logic [1:0] len;
        if (cp < 21'h80) begin
            len = LEN_1;
        end else if (cp < 21'h800) begin
            len = LEN_2;
        end else if (cp < 21'h1_0000) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 encoding of cp
    function automatic logic [7:0] utt_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (len_m1)
            LEN_1: begin
                b = {1'b0, cp[6:0]};
            end
            LEN_2: begin
                case (idx)
                    2'd0:    b = LEAD_2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = LEAD_3 | {4'h0, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = LEAD_4 | {5'h00, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

### sv/utt_front.sv
// Front end of the transcoder: accepts code units, pairs surrogates and
// classifies each unit into a job for the queue. Depends on utt_pkg.
module utt_front #(
    parameter int UNIT_BITS = utt_pkg::UNIT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  utt_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output utt_pkg::t_job     o_job,
    output logic              o_held
);
    import utt_pkg::*;

    localparam logic [32:0] MASK_WIDE = (33'd1 << UNIT_BITS) - 33'd1;
    localparam logic [31:0] UNIT_MASK = MASK_WIDE[31:0];

    logic        r_held;
    logic        n_held;
    logic [9:0]  r_pay;
    logic [9:0]  n_pay;
    logic [31:0] w_unit;
    logic        w_eot;
    logic        w_accept;
    logic        w_is_hi;
    logic        w_is_lo;
    logic        w_bad;
    logic        w_paired;
    t_job        w_job;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_unit   = i_item.code_unit & UNIT_MASK;
    assign w_eot    = i_item.end_of_text;

    // Range checks on the masked unit
    assign w_is_hi = (w_unit >= HI_FIRST) && (w_unit <= HI_LAST);
    assign w_is_lo = (w_unit >= LO_FIRST) && (w_unit <= LO_LAST);
    assign w_bad   = ((w_unit >= HI_FIRST) && (w_unit <= LO_LAST)) || (w_unit > MAX_CP);

    // Classification and next surrogate state
    always_comb begin
        w_job    = '0;
        w_paired = 1'b0;
        n_held   = r_held;
        n_pay    = r_pay;
        w_job.eot = w_eot;
        if (r_held) begin
            n_held = 1'b0;
            n_pay  = 10'd0;
            if (w_is_lo) begin
                w_paired     = 1'b1;
                w_job.has_cp = 1'b1;
                w_job.cp     = PAIR_BASE + {1'b0, r_pay, w_unit[9:0]};
            end else begin
                w_job.has_repl = 1'b1;
            end
        end
        if (!w_paired) begin
            if (w_is_hi && !w_eot) begin
                n_held = 1'b1;
                n_pay  = w_unit[9:0];
            end else if (w_bad) begin
                w_job.has_cp = 1'b1;
                w_job.cp     = REPLACEMENT;
            end else begin
                w_job.has_cp = 1'b1;
                w_job.cp     = w_unit[20:0];
            end
        end
        w_job.len_m1 = utt_len_m1(w_job.cp);
    end

    assign o_push = w_accept && (w_job.has_repl || w_job.has_cp);
    assign o_job  = w_job;
    assign o_held = r_held;

    // Held high surrogate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_pay  <= 10'd0;
        end else if (w_accept) begin
            r_held <= n_held;
            r_pay  <= n_pay;
        end
    end

endmodule

### sv/utt_queue.sv
// Short job queue between front and back end of the transcoder.
// Depends on utt_pkg for the job type.
module utt_queue #(
    parameter int QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utt_pkg::t_job i_job,
    input  logic          i_pop,
    output utt_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import utt_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == FULL_CNT);
    assign o_head    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/utt_back.sv
// Back end of the transcoder: takes jobs from the queue and sends one UTF-8 byte
// per cycle, while i_ready allows, through an output register. Depends on utt_pkg.
module utt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utt_pkg::t_job      i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output utt_pkg::t_out_item o_item
);
    import utt_pkg::*;

    t_job       r_cur;
    logic       r_cur_valid;
    logic       r_in_repl;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       w_advance;
    logic       w_emit;
    logic       w_final;
    logic       w_load;
    logic [7:0] w_byte;

    // Output register frees up when empty or being taken
    assign w_advance = !r_out_valid || i_ready;
    assign w_emit    = w_advance && r_cur_valid;

    // Final-byte flag and byte value of the current job
    always_comb begin
        if (r_in_repl) begin
            w_final = (r_idx == 2'd2) && !r_cur.has_cp;
            w_byte  = utt_byte(REPLACEMENT, LEN_3, r_idx);
        end else begin
            w_final = (r_idx == r_cur.len_m1);
            w_byte  = utt_byte(r_cur.cp, r_cur.len_m1, r_idx);
        end
    end

    assign w_load = (!r_cur_valid || (w_emit && w_final)) && !i_empty;
    assign o_pop  = w_load;

    // Job sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_in_repl   <= 1'b0;
            r_idx       <= 2'd0;
        end else if (w_load) begin
            r_cur_valid <= 1'b1;
            r_in_repl   <= i_head.has_repl;
            r_idx       <= 2'd0;
        end else if (w_emit) begin
            if (w_final) begin
                r_cur_valid <= 1'b0;
            end else if (r_in_repl && (r_idx == 2'd2)) begin
                r_in_repl <= 1'b0;
                r_idx     <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_head;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.utf8_byte   <= w_byte;
            r_out.last_of_run <= w_final;
            r_out.text_done   <= w_final && r_cur.eot;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

### sv/utf16_to_utf8_transcoder.sv
// UTF-16/UTF-32 to UTF-8 transcoder, top level. Uses utt_pkg, utt_front,
// utt_queue and utt_back.
// Path: an item's first byte passes the queue, job register and output register.
// Throughput: the back end's byte serialiser sends one output byte per cycle
// while i_ready is high; an item gives 1 to 7 bytes (0 for a held high surrogate).
// Reset: synchronous, active low; clears the held surrogate, queue and output.
module utf16_to_utf8_transcoder #(
    parameter int UNIT_BITS   = utt_pkg::UNIT_BITS_DEF,
    parameter int QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  utt_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output utt_pkg::t_out_item o_item
);
    import utt_pkg::*;

    logic w_push;
    t_job w_job;
    logic w_full;
    logic w_empty;
    logic w_pop;
    t_job w_head;
    logic w_held;

    utt_front #(
        .UNIT_BITS (UNIT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job),
        .o_held  (w_held)
    );

    utt_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    utt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // A push never hits a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // End of text leaves no surrogate held
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_item.end_of_text) |=> !w_held)
        else $error("surrogate still held after end of text");

    // Text end only on the final byte of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.text_done) |-> o_item.last_of_run)
        else $error("text_done without last_of_run");

endmodule
